/* hdl/utf8vr_pkg.sv */
// Shared types and constants for the UTF-8 validate/replace block.
// Used by the front classifier, the result queue, the serializer and the top level.
`default_nettype none

package utf8vr_pkg;

  // Most result bytes that one input byte can cause.
  localparam int MaxRes     = 6;
  localparam int ResCntW    = $clog2(MaxRes + 1);
  localparam int QueueDepth = 4;

  localparam logic [7:0] ContLo  = 8'h80;
  localparam logic [7:0] ContHi  = 8'hBF;
  localparam logic [7:0] Lead2Lo = 8'hC2;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] Lead3Ed = 8'hED;
  localparam logic [7:0] E0Lo    = 8'hA0;
  localparam logic [7:0] EdHi    = 8'h9F;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] Lead4Hi = 8'hF4;
  localparam logic [7:0] F0Lo    = 8'h90;
  localparam logic [7:0] F4Hi    = 8'h8F;

  // U+FFFD replacement character
  localparam logic [2:0][7:0] ReplSeq = {8'hBD, 8'hBF, 8'hEF};

  // All result bytes of one input byte, as one queue entry.
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [ResCntW-1:0]     cnt;
    logic                   last;
    logic                   err;
  } ent_t;

endpackage

`default_nettype wire

/* hdl/utf8vr_front.sv */
// Front end: decodes each accepted byte against the pending sequence and
// builds the result bytes it causes. Depends on utf8vr_pkg.
`default_nettype none

module utf8vr_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  input  wire logic            fatal_i,
  output utf8vr_pkg::ent_t     ent_o,
  output logic                 push_o
);

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      hcnt_q, hcnt_d;
  logic [1:0]      need_q, need_d;
  logic [7:0]      lo_q, lo_d;
  logic [7:0]      hi_q, hi_d;
  logic            failed_q, failed_d;

  utf8vr_pkg::ent_t ent;
  logic             do_lead;
  logic             any_inv;
  logic             err;

  function automatic utf8vr_pkg::ent_t put_byte(utf8vr_pkg::ent_t e, logic [7:0] b);
    if (e.cnt < utf8vr_pkg::ResCntW'(utf8vr_pkg::MaxRes)) begin
      e.bytes[e.cnt] = b;
      e.cnt          = e.cnt + utf8vr_pkg::ResCntW'(1);
    end
    return e;
  endfunction

  function automatic utf8vr_pkg::ent_t put_repl(utf8vr_pkg::ent_t e);
    for (int k = 0; k < 3; k++) begin
      e = put_byte(e, utf8vr_pkg::ReplSeq[k]);
    end
    return e;
  endfunction

  always_comb begin
    ent      = '0;
    ent.last = last_i;
    do_lead  = 1'b0;
    any_inv  = 1'b0;
    held_d   = held_q;
    hcnt_d   = hcnt_q;
    need_d   = need_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    failed_d = failed_q;

    if (need_q == 2'd0) begin
      do_lead = 1'b1;
    end else if (byte_i >= lo_q && byte_i <= hi_q) begin
      if (need_q == 2'd1) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < hcnt_q) ent = put_byte(ent, held_q[i]);
        end
        ent    = put_byte(ent, byte_i);
        hcnt_d = 2'd0;
        need_d = 2'd0;
      end else begin
        if (hcnt_q < 2'd3) begin
          held_d[hcnt_q] = byte_i;
          hcnt_d         = hcnt_q + 2'd1;
        end
        need_d = need_q - 2'd1;
      end
      lo_d = utf8vr_pkg::ContLo;
      hi_d = utf8vr_pkg::ContHi;
    end else begin
      // broken sequence: replace it, then decode this byte afresh
      any_inv = 1'b1;
      ent     = put_repl(ent);
      hcnt_d  = 2'd0;
      need_d  = 2'd0;
      lo_d    = utf8vr_pkg::ContLo;
      hi_d    = utf8vr_pkg::ContHi;
      do_lead = 1'b1;
    end

    if (do_lead) begin
      if (!byte_i[7]) begin
        ent = put_byte(ent, byte_i);
      end else begin
        lo_d      = utf8vr_pkg::ContLo;
        hi_d      = utf8vr_pkg::ContHi;
        held_d[0] = byte_i;
        hcnt_d    = 2'd1;
        if (byte_i >= utf8vr_pkg::Lead2Lo && byte_i <= utf8vr_pkg::Lead2Hi) begin
          need_d = 2'd1;
        end else if (byte_i >= utf8vr_pkg::Lead3Lo && byte_i <= utf8vr_pkg::Lead3Hi) begin
          need_d = 2'd2;
          if (byte_i == utf8vr_pkg::Lead3Lo) lo_d = utf8vr_pkg::E0Lo;
          if (byte_i == utf8vr_pkg::Lead3Ed) hi_d = utf8vr_pkg::EdHi;
        end else if (byte_i >= utf8vr_pkg::Lead4Lo && byte_i <= utf8vr_pkg::Lead4Hi) begin
          need_d = 2'd3;
          if (byte_i == utf8vr_pkg::Lead4Lo) lo_d = utf8vr_pkg::F0Lo;
          if (byte_i == utf8vr_pkg::Lead4Hi) hi_d = utf8vr_pkg::F4Hi;
        end else begin
          any_inv = 1'b1;
          ent     = put_repl(ent);
          hcnt_d  = 2'd0;
          need_d  = 2'd0;
        end
      end
    end

    // sequence cut off by end of stream
    if (last_i && need_d != 2'd0) begin
      any_inv = 1'b1;
      ent     = put_repl(ent);
      hcnt_d  = 2'd0;
      need_d  = 2'd0;
      lo_d    = utf8vr_pkg::ContLo;
      hi_d    = utf8vr_pkg::ContHi;
    end

    err = fatal_i && any_inv;
    if (err) begin
      ent       = '0;
      ent.cnt   = utf8vr_pkg::ResCntW'(1);
      ent.last  = last_i;
      ent.err   = 1'b1;
      failed_d  = !last_i;
      hcnt_d    = 2'd0;
      need_d    = 2'd0;
      lo_d      = utf8vr_pkg::ContLo;
      hi_d      = utf8vr_pkg::ContHi;
    end

    // dropping after a fatal error until the end of the stream
    if (failed_q) begin
      ent      = '0;
      held_d   = held_q;
      hcnt_d   = hcnt_q;
      need_d   = need_q;
      lo_d     = lo_q;
      hi_d     = hi_q;
      failed_d = 1'b1;
      if (last_i) begin
        failed_d = 1'b0;
        hcnt_d   = 2'd0;
        need_d   = 2'd0;
        lo_d     = utf8vr_pkg::ContLo;
        hi_d     = utf8vr_pkg::ContHi;
      end
    end
  end

  assign ent_o  = ent;
  assign push_o = fire_i && (ent.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q   <= 2'd0;
      need_q   <= 2'd0;
      lo_q     <= utf8vr_pkg::ContLo;
      hi_q     <= utf8vr_pkg::ContHi;
      failed_q <= 1'b0;
    end else if (fire_i) begin
      hcnt_q   <= hcnt_d;
      need_q   <= need_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      failed_q <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) held_q <= held_d;
  end

endmodule

`default_nettype wire

/* hdl/utf8vr_queue.sv */
// Short queue of result entries between front end and serializer.
// Depends on utf8vr_pkg.
`default_nettype none

module utf8vr_queue #(
  parameter int Depth = utf8vr_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire utf8vr_pkg::ent_t ent_i,
  input  wire logic             pop_i,
  output utf8vr_pkg::ent_t      head_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  utf8vr_pkg::ent_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= ent_i;
  end

endmodule

`default_nettype wire

/* hdl/utf8vr_back.sv */
// Back end: walks the head queue entry and sends its bytes one per transfer.
// Depends on utf8vr_pkg.
`default_nettype none

module utf8vr_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire utf8vr_pkg::ent_t head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [7:0]            byte_o,
  output logic                  run_last_o,
  output logic                  stream_end_o,
  output logic                  error_o
);

  logic [utf8vr_pkg::ResCntW-1:0] idx_q;
  logic                           xfer;

  assign valid_o      = !empty_i;
  assign byte_o       = head_i.bytes[idx_q];
  assign run_last_o   = (idx_q == head_i.cnt - utf8vr_pkg::ResCntW'(1));
  assign stream_end_o = run_last_o && head_i.last;
  assign error_o      = head_i.err;
  assign xfer         = valid_o && ready_i;
  assign pop_o        = xfer && run_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (xfer) begin
      idx_q <= run_last_o ? '0 : idx_q + utf8vr_pkg::ResCntW'(1);
    end
  end

endmodule

`default_nettype wire

/* hdl/utf8_validate_replace.sv */
// Top level of the streaming UTF-8 validate/replace block.
// Instantiates utf8vr_front, utf8vr_queue and utf8vr_back; uses utf8vr_pkg.
//
// One input byte can be taken every cycle while the queue is not full; its results
// (up to six bytes) sit in a QueueDepth-entry queue and leave one byte per output
// transfer, the first once its entry is in the queue and at its head. Valid text
// runs at one byte per cycle in and out while the output is ready; a replacement
// costs three output bytes, so once the queue fills the output side sets the rate:
// tready is low exactly while the queue is full. fatal_mode is written through cfg_we_i.
`default_nettype none

module utf8_validate_replace #(
  parameter int QueueDepth = utf8vr_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,      // fatal_mode
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,     // [7:0] in_byte
  input  wire logic       s_axis_tlast,     // in_last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,     // [7:0] out_byte
  output logic            m_axis_tlast,     // stream_end
  output logic [1:0]      m_axis_tuser      // [0] run_last, [1] error
);

  logic             fatal_q;
  logic             fire;
  logic             push;
  logic             pop;
  logic             q_empty, q_full;
  utf8vr_pkg::ent_t ent, head;
  logic             run_last, err_flag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fatal_q <= 1'b0;
    else if (cfg_we_i) fatal_q <= cfg_wdata_i;
  end

  assign s_axis_tready = !q_full;
  assign fire          = s_axis_tvalid && s_axis_tready;

  utf8vr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .fatal_i (fatal_q),
    .ent_o   (ent),
    .push_o  (push)
  );

  utf8vr_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  utf8vr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .byte_o       (m_axis_tdata),
    .run_last_o   (run_last),
    .stream_end_o (m_axis_tlast),
    .error_o      (err_flag)
  );

  assign m_axis_tuser = {err_flag, run_last};

  // a run of results is never split by a gap in valid
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tuser[0] |=> m_axis_tvalid)
    else $error("result run broken before its last byte");

  // fatal error result stands alone with a zero byte
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && (m_axis_tdata == 8'h00))
    else $error("error result not a single zero byte");

  // end of stream only on the last byte of a run
  a_end_on_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("stream end before end of run");

  // a push never meets a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("queue overflow");

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench for utf8_validate_replace: directed rows, then random byte streams.
// Depends on utf8vr_pkg and the utf8_validate_replace RTL; self-checking, no files.
`timescale 1ns / 100ps

module tb;

  localparam logic ModeReplace = 1'b0;
  localparam logic ModeFatal   = 1'b1;
  localparam logic [23:0] Repl = 24'hEFBFBD;
  localparam int DrainCycles   = 12;

  // One input byte, optionally with its results typed in (bytes right-aligned in r,
  // first byte highest).
  typedef struct packed {
    logic        mode;
    logic [7:0]  b;
    logic        last;
    logic        typed;
    logic        err;
    logic [1:0]  n;
    logic [23:0] r;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       stream_end;
    logic       err;
  } out_rec_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i, cfg_wdata_i;
  logic       s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  utf8_validate_replace uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  dir_row_t dir_tab [28] = '{
    '{ModeReplace, 8'h00, 0, 1, 0, 1, 24'h00},
    '{ModeReplace, 8'h7F, 0, 1, 0, 1, 24'h7F},
    '{ModeReplace, 8'h80, 0, 1, 0, 3, Repl},
    '{ModeReplace, 8'hFF, 0, 1, 0, 3, Repl},
    '{ModeReplace, 8'hC1, 0, 1, 0, 3, Repl},
    '{ModeReplace, 8'hF5, 0, 1, 0, 3, Repl},
    '{ModeReplace, 8'hC2, 0, 1, 0, 0, 24'h0},
    '{ModeReplace, 8'h80, 0, 1, 0, 2, 24'hC280},
    '{ModeReplace, 8'hE0, 0, 1, 0, 0, 24'h0},
    '{ModeReplace, 8'hA0, 0, 1, 0, 0, 24'h0},
    '{ModeReplace, 8'hBF, 0, 1, 0, 3, 24'hE0A0BF},
    '{ModeReplace, 8'hE0, 0, 1, 0, 0, 24'h0},
    '{ModeReplace, 8'h9F, 0, 0, 0, 0, 24'h0},   // below E0 bound, then bad lead
    '{ModeReplace, 8'hED, 0, 1, 0, 0, 24'h0},
    '{ModeReplace, 8'hA0, 0, 0, 0, 0, 24'h0},   // above ED bound
    '{ModeReplace, 8'hF4, 0, 1, 0, 0, 24'h0},
    '{ModeReplace, 8'h90, 0, 0, 0, 0, 24'h0},   // above F4 bound
    '{ModeReplace, 8'hE2, 0, 1, 0, 0, 24'h0},
    '{ModeReplace, 8'h82, 1, 1, 0, 3, Repl},    // cut off at end of stream
    '{ModeFatal,   8'hC3, 0, 1, 0, 0, 24'h0},
    '{ModeFatal,   8'h41, 0, 1, 1, 0, 24'h0},
    '{ModeFatal,   8'h42, 1, 1, 0, 0, 24'h0},   // dropped, ends the stream
    '{ModeFatal,   8'hFF, 1, 1, 1, 0, 24'h0},
    '{ModeFatal,   8'hE2, 0, 1, 0, 0, 24'h0},
    '{ModeReplace, 8'h41, 0, 0, 0, 0, 24'h0},   // mode switched with E2 pending
    '{ModeFatal,   8'hC0, 0, 1, 1, 0, 24'h0},
    '{ModeReplace, 8'h41, 1, 1, 0, 0, 24'h0},   // still dropping after mode clear
    '{ModeReplace, 8'h43, 1, 1, 0, 1, 24'h43}
  };

  // Decoder state as seen from outside
  logic [7:0] seq_bytes [3];
  logic [1:0] seq_cnt, seq_need;
  logic [7:0] lo_bound, hi_bound;
  logic       dropping, mode_q, step_err;
  logic [7:0] step_bytes [$];

  out_rec_t   out_due [$];
  dir_row_t   sent_rows [$];
  logic [7:0] unit_q [$];
  int         live_cnt;
  logic       idle_on, mismatch_seen;

  function automatic void seq_clear();
    seq_cnt  = '0;
    seq_need = '0;
    lo_bound = utf8vr_pkg::ContLo;
    hi_bound = utf8vr_pkg::ContHi;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    if (step_bytes.size() < utf8vr_pkg::MaxRes) step_bytes.push_back(b);
  endfunction

  function automatic void seq_keep(logic [7:0] b);
    if (seq_cnt < 3) begin
      seq_bytes[seq_cnt] = b;
      seq_cnt++;
    end
  endfunction

  function automatic void flag_invalid();
    seq_clear();
    if (mode_q == ModeFatal) step_err = 1'b1;
    else for (int k = 0; k < 3; k++) put_byte(utf8vr_pkg::ReplSeq[k]);
  endfunction

  function automatic void start_seq(logic [7:0] b);
    if (b < utf8vr_pkg::ContLo) begin
      put_byte(b);
      return;
    end
    lo_bound = utf8vr_pkg::ContLo;
    hi_bound = utf8vr_pkg::ContHi;
    if (b >= utf8vr_pkg::Lead2Lo && b <= utf8vr_pkg::Lead2Hi) begin
      seq_need = 2'd1;
    end else if (b >= utf8vr_pkg::Lead3Lo && b <= utf8vr_pkg::Lead3Hi) begin
      seq_need = 2'd2;
      if (b == utf8vr_pkg::Lead3Lo) lo_bound = utf8vr_pkg::E0Lo;
      if (b == utf8vr_pkg::Lead3Ed) hi_bound = utf8vr_pkg::EdHi;
    end else if (b >= utf8vr_pkg::Lead4Lo && b <= utf8vr_pkg::Lead4Hi) begin
      seq_need = 2'd3;
      if (b == utf8vr_pkg::Lead4Lo) lo_bound = utf8vr_pkg::F0Lo;
      if (b == utf8vr_pkg::Lead4Hi) hi_bound = utf8vr_pkg::F4Hi;
    end else begin
      flag_invalid();
      return;
    end
    seq_cnt = '0;
    seq_keep(b);
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    if (seq_need == 0) begin
      start_seq(b);
    end else if (b >= lo_bound && b <= hi_bound) begin
      if (seq_need == 1) begin
        for (int k = 0; k < seq_cnt; k++) put_byte(seq_bytes[k]);
        put_byte(b);
        seq_clear();
      end else begin
        seq_keep(b);
        seq_need--;
        lo_bound = utf8vr_pkg::ContLo;
        hi_bound = utf8vr_pkg::ContHi;
      end
    end else begin
      // the breaking byte is decoded again as a fresh lead
      flag_invalid();
      if (!step_err) start_seq(b);
    end
  endfunction

  function automatic void sanitize_byte(logic [7:0] b, logic last);
    dir_row_t row;
    out_rec_t rec;
    row = sent_rows.pop_front();
    step_bytes.delete();
    step_err = 1'b0;
    live_cnt++;
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        seq_clear();
      end
    end else begin
      decode_byte(b);
      if (!step_err && last && seq_need != 0) flag_invalid();
      if (step_err) begin
        seq_clear();
        dropping = !last;
      end
    end
    if (row.typed) begin
      step_err = row.err;
      step_bytes.delete();
      for (int k = int'(row.n) - 1; k >= 0; k--) step_bytes.push_back(row.r[k*8 +: 8]);
    end
    if (step_err) begin
      rec.data       = 8'h00;
      rec.run_last   = 1'b1;
      rec.stream_end = last;
      rec.err        = 1'b1;
      out_due.push_back(rec);
    end else begin
      foreach (step_bytes[k]) begin
        rec.data       = step_bytes[k];
        rec.run_last   = (k == step_bytes.size() - 1);
        rec.stream_end = last && (k == step_bytes.size() - 1);
        rec.err        = 1'b0;
        out_due.push_back(rec);
      end
    end
  endfunction

  function automatic void check_result();
    out_rec_t want;
    if (out_due.size() == 0) begin
      $error("unexpected output transfer: out_byte %h", m_axis_tdata);
      mismatch_seen = 1'b1;
      return;
    end
    want = out_due.pop_front();
    if (m_axis_tdata !== want.data) begin
      $error("out_byte: expected %h, got %h", want.data, m_axis_tdata);
      mismatch_seen = 1'b1;
    end
    if (m_axis_tuser[0] !== want.run_last) begin
      $error("run_last: expected %b, got %b", want.run_last, m_axis_tuser[0]);
      mismatch_seen = 1'b1;
    end
    if (m_axis_tlast !== want.stream_end) begin
      $error("stream_end: expected %b, got %b", want.stream_end, m_axis_tlast);
      mismatch_seen = 1'b1;
    end
    if (m_axis_tuser[1] !== want.err) begin
      $error("error: expected %b, got %b", want.err, m_axis_tuser[1]);
      mismatch_seen = 1'b1;
    end
  endfunction

  // Outputs are checked before the new input is predicted, so same-edge order is fixed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) sanitize_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  // Receiver: random stall bursts while idling is on
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 7);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input dir_row_t row);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    sent_rows.push_back(row);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.b;
    s_axis_tlast  <= row.last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(input logic [7:0] b, input logic last);
    dir_row_t row;
    row      = '0;
    row.mode = mode_q;
    row.b    = b;
    row.last = last;
    send_byte(row);
  endtask

  // Stop sending, wait for every pending result, then let held bytes settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (out_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
  endtask

  // One code point: mostly well-formed, some broken, some noise.
  task automatic make_unit();
    int kind, len;
    logic [7:0] lead, lo, hi;
    unit_q.delete();
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      unit_q.push_back(8'($urandom_range(0, 8'h7F)));
    end else if (kind < 8) begin
      len = $urandom_range(2, 4);
      case (len)
        2: lead = 8'($urandom_range(utf8vr_pkg::Lead2Lo, utf8vr_pkg::Lead2Hi));
        3: lead = 8'($urandom_range(utf8vr_pkg::Lead3Lo, utf8vr_pkg::Lead3Hi));
        default: lead = 8'($urandom_range(utf8vr_pkg::Lead4Lo, utf8vr_pkg::Lead4Hi));
      endcase
      lo = utf8vr_pkg::ContLo;
      hi = utf8vr_pkg::ContHi;
      if (lead == utf8vr_pkg::Lead3Lo) lo = utf8vr_pkg::E0Lo;
      if (lead == utf8vr_pkg::Lead3Ed) hi = utf8vr_pkg::EdHi;
      if (lead == utf8vr_pkg::Lead4Lo) lo = utf8vr_pkg::F0Lo;
      if (lead == utf8vr_pkg::Lead4Hi) hi = utf8vr_pkg::F4Hi;
      unit_q.push_back(lead);
      unit_q.push_back(8'($urandom_range(lo, hi)));
      repeat (len - 2)
        unit_q.push_back(8'($urandom_range(utf8vr_pkg::ContLo, utf8vr_pkg::ContHi)));
      if (kind == 7) begin
        case ($urandom_range(0, 2))
          0: void'(unit_q.pop_back());
          1: unit_q[$urandom_range(1, unit_q.size() - 1)] = 8'($urandom_range(0, 255));
          default: unit_q[1] = $urandom_range(0, 1) ? lo - 8'd1 : hi + 8'd1;
        endcase
      end
    end else begin
      unit_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int target;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    mode_q        = ModeReplace;
    dropping      = 1'b0;
    live_cnt      = 0;
    mismatch_seen = 1'b0;
    idle_on       = 1'b1;
    seq_clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].mode != mode_q) begin
        drain();
        write_mode(dir_tab[i].mode);
      end
      send_byte(dir_tab[i]);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_mode(ph == 5 ? logic'($urandom_range(0, 1)) : logic'(ph % 2));
      idle_on = (ph != 2) && (ph != 5);
      target  = live_cnt + 65;
      while (live_cnt < target) begin
        make_unit();
        foreach (unit_q[i])
          send_random(unit_q[i], $urandom_range(0, mode_q == ModeFatal ? 5 : 15) == 0);
      end
    end
    send_random(8'($urandom_range(0, 255)), 1'b1);
    drain();

    if (!mismatch_seen && out_due.size() == 0) begin
      $display("utf8_validate_replace regression: pass");
    end else begin
      $display("utf8_validate_replace regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("utf8_validate_replace regression: fail");
    $finish;
  end

endmodule
